/* src/cle_pkg.sv */
`timescale 1ns / 1ps
package cle_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 4;
   localparam int ERR_W    = 2;

   localparam logic [CMD_W-1:0] CMD_QUERY      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_FRONT      = 4'd1;
   localparam logic [CMD_W-1:0] CMD_BACK       = 4'd2;
   localparam logic [CMD_W-1:0] CMD_PREV       = 4'd3;
   localparam logic [CMD_W-1:0] CMD_NEXT       = 4'd4;
   localparam logic [CMD_W-1:0] CMD_PREPEND    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_APPEND     = 4'd6;
   localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 4'd7;
   localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 4'd8;
   localparam logic [CMD_W-1:0] CMD_DEL_FRONT  = 4'd9;
   localparam logic [CMD_W-1:0] CMD_DEL_BACK   = 4'd10;
   localparam logic [CMD_W-1:0] CMD_DEL_CURSOR = 4'd11;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd12;

   localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_CURSOR = 2'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_FULL   = 2'd3;

   typedef struct packed {
      logic capture;
      logic decode;
      logic exec;
      logic exec2;
      logic rd_head;
      logic rd_tail;
      logic rd_cur;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic two_step;
   } status_type;

endpackage

/* src/cle_ram.sv */
`timescale 1ns / 1ps
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/cle_ctrl.sv */
`timescale 1ns / 1ps
module cle_ctrl
   import cle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output ctl_type    ctl,
   output logic       busy
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_EXEC, ST_EXEC2, ST_RD_HEAD, ST_RD_TAIL, ST_RD_CUR, ST_LAST
   } state_type;

   state_type state_ff, state_in;
   ctl_type   ctl_ff, ctl_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (start) state_in = ST_DECODE;
         ST_DECODE:  state_in = ST_EXEC;
         ST_EXEC:    state_in = status.two_step ? ST_EXEC2 : ST_RD_HEAD;
         ST_EXEC2:   state_in = ST_RD_HEAD;
         ST_RD_HEAD: state_in = ST_RD_TAIL;
         ST_RD_TAIL: state_in = ST_RD_CUR;
         ST_RD_CUR:  state_in = ST_LAST;
         ST_LAST:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
      ctl_in = '0;
      ctl_in.capture = (state_in == ST_IDLE);
      ctl_in.decode  = (state_in == ST_DECODE);
      ctl_in.exec    = (state_in == ST_EXEC);
      ctl_in.exec2   = (state_in == ST_EXEC2);
      ctl_in.rd_head = (state_in == ST_RD_HEAD);
      ctl_in.rd_tail = (state_in == ST_RD_TAIL);
      ctl_in.rd_cur  = (state_in == ST_RD_CUR);
      ctl_in.finish  = (state_in == ST_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctl_ff   <= '{capture: 1'b1, default: 1'b0};
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctl_ff   <= ctl_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign ctl  = ctl_ff;
   assign busy = busy_ff;

endmodule

/* src/cle_datapath.sv */
`timescale 1ns / 1ps
module cle_datapath
   import cle_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_type                   ctl,
   output status_type                status,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   output logic [ERR_W-1:0]          rsp_error,
   output logic [CNT_W-1:0]          rsp_list_length,
   output logic signed [CNT_W-1:0]   rsp_cursor_position,
   output logic signed [VALUE_W-1:0] rsp_front_value,
   output logic signed [VALUE_W-1:0] rsp_back_value,
   output logic signed [VALUE_W-1:0] rsp_cursor_value
);

   typedef enum logic [3:0] {
      OP_NONE, OP_FRONT, OP_BACK, OP_PREV, OP_NEXT, OP_PREPEND, OP_APPEND,
      OP_INS_BEFORE, OP_INS_AFTER, OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_CUR,
      OP_DEL_CUR_FRONT, OP_CLEAR
   } op_type;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [CMD_W-1:0]   cmd_ff;
   logic [VALUE_W-1:0] val_ff;
   op_type             op_ff, op_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [IDX_W-1:0]   head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [CNT_W-1:0]   pos_ff, pos_in, cnt_ff, cnt_in;
   logic [CNT_W-1:0]   fresh_ff, fresh_in, fcnt_ff, fcnt_in;
   logic [IDX_W-1:0]   n_ff, p_ff, nx_ff;
   logic [VALUE_W-1:0] front_ff, back_ff;
   logic               rsp_valid_ff;
   logic [ERR_W-1:0]   rsp_error_ff;
   logic [CNT_W-1:0]   rsp_len_ff, rsp_pos_ff;
   logic [VALUE_W-1:0] rsp_front_ff, rsp_back_ff, rsp_cur_ff;

   logic               cur_def, full, at_front, at_back;
   logic [IDX_W-1:0]   n_new, p_rd, nx_rd, stk_rd;
   logic [VALUE_W-1:0] val_rd;
   logic [CNT_W-1:0]   last_pos;

   logic               val_we, nxt_we, prv_we, stk_we;
   logic [IDX_W-1:0]   val_ra, nxt_wa, nxt_wd, nxt_ra, prv_wa, prv_wd, prv_ra;
   logic [IDX_W-1:0]   stk_wa, stk_wd, stk_ra;

   assign cur_def  = ~pos_ff[CNT_W-1];
   assign last_pos = cnt_ff - CNT_W'(1);
   assign full     = (cnt_ff == CAP_CNT);
   assign at_front = (pos_ff == '0);
   assign at_back  = (pos_ff == last_pos);
   assign n_new    = (fcnt_ff != '0) ? stk_rd : fresh_ff[IDX_W-1:0];

   always_comb begin
      op_in  = OP_NONE;
      err_in = ERR_OK;
      case (cmd_ff)
         CMD_FRONT: if (cnt_ff != '0) op_in = OP_FRONT;
         CMD_BACK:  if (cnt_ff != '0) op_in = OP_BACK;
         CMD_PREV:  if (cur_def) op_in = OP_PREV;
         CMD_NEXT:  if (cur_def) op_in = OP_NEXT;
         CMD_PREPEND, CMD_APPEND: begin
            if (full) err_in = ERR_FULL;
            else op_in = (cmd_ff == CMD_PREPEND) ? OP_PREPEND : OP_APPEND;
         end
         CMD_INS_BEFORE: begin
            if (!cur_def) err_in = ERR_CURSOR;
            else if (full) err_in = ERR_FULL;
            else op_in = at_front ? OP_PREPEND : OP_INS_BEFORE;
         end
         CMD_INS_AFTER: begin
            if (!cur_def) err_in = ERR_CURSOR;
            else if (full) err_in = ERR_FULL;
            else op_in = at_back ? OP_APPEND : OP_INS_AFTER;
         end
         CMD_DEL_FRONT, CMD_DEL_BACK: begin
            if (cnt_ff == '0) err_in = ERR_EMPTY;
            else op_in = (cmd_ff == CMD_DEL_FRONT) ? OP_DEL_FRONT : OP_DEL_BACK;
         end
         CMD_DEL_CURSOR: begin
            if (!cur_def) err_in = ERR_CURSOR;
            else op_in = at_front ? OP_DEL_CUR_FRONT : OP_DEL_CUR;
         end
         CMD_CLEAR: op_in = OP_CLEAR;
         default:   op_in = OP_NONE;
      endcase
   end

   // read addresses: links at decode, values during the read-out
   assign nxt_ra = (cmd_ff == CMD_DEL_FRONT) ? head_ff : cur_ff;
   assign prv_ra = (cmd_ff == CMD_DEL_BACK) ? tail_ff : cur_ff;
   assign stk_ra = fcnt_ff[IDX_W-1:0] - IDX_W'(1);
   assign val_ra = ctl.rd_head ? head_ff : (ctl.rd_tail ? tail_ff : cur_ff);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      cur_in   = cur_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      fresh_in = fresh_ff;
      fcnt_in  = fcnt_ff;
      val_we = 1'b0;
      nxt_we = 1'b0; nxt_wa = n_new; nxt_wd = head_ff;
      prv_we = 1'b0; prv_wa = n_new; prv_wd = tail_ff;
      stk_we = 1'b0; stk_wa = fcnt_ff[IDX_W-1:0]; stk_wd = cur_ff;
      if (ctl.exec) begin
         if (op_ff == OP_PREPEND || op_ff == OP_APPEND || op_ff == OP_INS_BEFORE
             || op_ff == OP_INS_AFTER) begin
            val_we = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (fcnt_ff != '0) fcnt_in = fcnt_ff - CNT_W'(1);
            else fresh_in = fresh_ff + CNT_W'(1);
         end
         if (op_ff == OP_DEL_FRONT || op_ff == OP_DEL_CUR_FRONT || op_ff == OP_DEL_BACK
             || op_ff == OP_DEL_CUR) begin
            stk_we  = 1'b1;
            fcnt_in = fcnt_ff + CNT_W'(1);
            cnt_in  = cnt_ff - CNT_W'(1);
         end
         case (op_ff)
            OP_FRONT: begin
               cur_in = head_ff;
               pos_in = '0;
            end
            OP_BACK: begin
               cur_in = tail_ff;
               pos_in = last_pos;
            end
            OP_PREV: begin
               if (at_front) pos_in = '1;
               else begin
                  cur_in = p_rd;
                  pos_in = pos_ff - CNT_W'(1);
               end
            end
            OP_NEXT: begin
               if (at_back) pos_in = '1;
               else begin
                  cur_in = nx_rd;
                  pos_in = pos_ff + CNT_W'(1);
               end
            end
            OP_PREPEND: begin
               nxt_we = 1'b1; nxt_wa = n_new; nxt_wd = head_ff;
               prv_we = (cnt_ff != '0); prv_wa = head_ff; prv_wd = n_new;
               if (cnt_ff == '0) tail_in = n_new;
               head_in = n_new;
               if (cur_def) pos_in = pos_ff + CNT_W'(1);
            end
            OP_APPEND: begin
               nxt_we = (cnt_ff != '0); nxt_wa = tail_ff; nxt_wd = n_new;
               prv_we = 1'b1; prv_wa = n_new; prv_wd = tail_ff;
               if (cnt_ff == '0) head_in = n_new;
               tail_in = n_new;
            end
            OP_INS_BEFORE: begin
               nxt_we = 1'b1; nxt_wa = n_new; nxt_wd = cur_ff;
               prv_we = 1'b1; prv_wa = n_new; prv_wd = p_rd;
               pos_in = pos_ff + CNT_W'(1);
            end
            OP_INS_AFTER: begin
               nxt_we = 1'b1; nxt_wa = n_new; nxt_wd = nx_rd;
               prv_we = 1'b1; prv_wa = n_new; prv_wd = cur_ff;
            end
            OP_DEL_FRONT, OP_DEL_CUR_FRONT: begin
               stk_wd = head_ff;
               if (cnt_ff == CNT_W'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else begin
                  head_in = nx_rd;
               end
               if (op_ff == OP_DEL_CUR_FRONT || at_front) pos_in = '1;
               else if (cur_def) pos_in = pos_ff - CNT_W'(1);
            end
            OP_DEL_BACK: begin
               stk_wd = tail_ff;
               if (cnt_ff == CNT_W'(1)) begin
                  pos_in  = '1;
                  head_in = '0;
                  tail_in = '0;
               end else begin
                  if (cur_def && at_back) pos_in = '1;
                  tail_in = p_rd;
               end
            end
            OP_DEL_CUR: begin
               stk_wd = cur_ff;
               nxt_we = 1'b1; nxt_wa = p_rd; nxt_wd = nx_rd;
               if (at_back) tail_in = p_rd;
               else begin
                  prv_we = 1'b1; prv_wa = nx_rd; prv_wd = p_rd;
               end
               pos_in = '1;
            end
            OP_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               cur_in   = '0;
               pos_in   = '1;
               cnt_in   = '0;
               fresh_in = '0;
               fcnt_in  = '0;
            end
            default: begin
            end
         endcase
      end else if (ctl.exec2) begin
         if (op_ff == OP_INS_BEFORE) begin
            nxt_we = 1'b1; nxt_wa = p_ff; nxt_wd = n_ff;
            prv_we = 1'b1; prv_wa = cur_ff; prv_wd = n_ff;
         end else begin
            nxt_we = 1'b1; nxt_wa = cur_ff; nxt_wd = n_ff;
            prv_we = 1'b1; prv_wa = nx_ff; prv_wd = n_ff;
         end
      end
   end

   cle_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value (
      .clock(clock), .wr_en(val_we), .wr_addr(n_new), .wr_data(val_ff),
      .rd_addr(val_ra), .rd_data(val_rd)
   );

   cle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(nxt_ra), .rd_data(nx_rd)
   );

   cle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(prv_ra), .rd_data(p_rd)
   );

   cle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         cur_ff       <= '0;
         pos_ff       <= '1;
         cnt_ff       <= '0;
         fresh_ff     <= '0;
         fcnt_ff      <= '0;
         op_ff        <= OP_NONE;
         err_ff       <= ERR_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cur_ff       <= cur_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         fresh_ff     <= fresh_in;
         fcnt_ff      <= fcnt_in;
         if (ctl.decode) begin
            op_ff  <= op_in;
            err_ff <= err_in;
         end
         rsp_valid_ff <= ctl.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= req_cmd;
         val_ff <= req_value;
      end
      if (ctl.exec) begin
         n_ff  <= n_new;
         p_ff  <= p_rd;
         nx_ff <= nx_rd;
      end
      if (ctl.rd_tail) front_ff <= val_rd;
      if (ctl.rd_cur) back_ff <= val_rd;
      if (ctl.finish) begin
         rsp_error_ff <= err_ff;
         rsp_len_ff   <= cnt_ff;
         rsp_pos_ff   <= pos_ff;
         rsp_front_ff <= (cnt_ff != '0) ? front_ff : '0;
         rsp_back_ff  <= (cnt_ff != '0) ? back_ff : '0;
         rsp_cur_ff   <= cur_def ? val_rd : '0;
      end
   end

   assign status.two_step    = (op_ff == OP_INS_BEFORE) || (op_ff == OP_INS_AFTER);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_error           = rsp_error_ff;
   assign rsp_list_length     = rsp_len_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_front_value     = rsp_front_ff;
   assign rsp_back_value      = rsp_back_ff;
   assign rsp_cursor_value    = rsp_cur_ff;

`ifndef SYNTH
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result strobe held");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAP_CNT) else $error("length beyond capacity");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      cur_def |-> (pos_ff < cnt_ff)) else $error("cursor beyond list");
   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      fresh_ff == cnt_ff + fcnt_ff) else $error("slot accounting lost");
`endif

endmodule

/* src/cursor_list_engine.sv */
`timescale 1ns / 1ps
// Bounded doubly linked list (64 nodes) with one cursor. Raise start while busy is low to
// issue a request; busy stays high while it runs, longer for an insert before a cursor not
// at the front or after one not at the back, which writes two links in each link memory.
// The result appears on the rsp_ ports for exactly one cycle with rsp_valid, the first
// cycle with busy low again; it cannot be held off, so capture it then. A new request may
// be issued in that same cycle. The node memories each have one read and one write port,
// so a request runs a link read, one or two link writes, then three value reads for front,
// back and cursor; clear is no slower than other requests. No warm-up after reset.
module cursor_list_engine
   import cle_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   output logic [ERR_W-1:0]          rsp_error,
   output logic [CNT_W-1:0]          rsp_list_length,
   output logic signed [CNT_W-1:0]   rsp_cursor_position,
   output logic signed [VALUE_W-1:0] rsp_front_value,
   output logic signed [VALUE_W-1:0] rsp_back_value,
   output logic signed [VALUE_W-1:0] rsp_cursor_value
);

   ctl_type    ctl;
   status_type status;

   cle_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .status(status), .ctl(ctl), .busy(busy)
   );

   cle_datapath u_datapath (
      .clock(clock), .reset(reset), .ctl(ctl), .status(status),
      .req_cmd(req_cmd), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_error(rsp_error), .rsp_list_length(rsp_list_length),
      .rsp_cursor_position(rsp_cursor_position), .rsp_front_value(rsp_front_value),
      .rsp_back_value(rsp_back_value), .rsp_cursor_value(rsp_cursor_value)
   );

endmodule

/* tb/cursor_list_engine_tb.sv */
`timescale 1ns / 1ps
module cursor_list_engine_tb;
   import cle_pkg::*;

   typedef struct {
      logic [ERR_W-1:0]          err;
      logic [CNT_W-1:0]          len;
      logic [CNT_W-1:0]          pos;
      logic signed [VALUE_W-1:0] front;
      logic signed [VALUE_W-1:0] back;
      logic signed [VALUE_W-1:0] curv;
   } list_view_type;

   class list_scoreboard;
      logic signed [VALUE_W-1:0] node_val [CAPACITY];
      int node_nxt [CAPACITY];
      int node_prv [CAPACITY];
      int free_stack [CAPACITY];
      int free_n, head, tail, cur_slot, cur_pos, count;
      list_view_type pending [$];
      int errors;

      function new();
         errors = 0;
         wipe();
      endfunction

      function void wipe();
         for (int i = 0; i < CAPACITY; i++) free_stack[i] = i;
         free_n = CAPACITY;
         head = 0; tail = 0; cur_slot = 0; cur_pos = -1; count = 0;
      endfunction

      function int alloc(logic signed [VALUE_W-1:0] v);
         int n;
         free_n--;
         n = free_stack[free_n];
         node_val[n] = v; node_nxt[n] = 0; node_prv[n] = 0;
         return n;
      endfunction

      function void give_back(int n);
         if (free_n < CAPACITY) begin
            free_stack[free_n] = n;
            free_n++;
         end
      endfunction

      function void push_front(logic signed [VALUE_W-1:0] v);
         int n;
         n = alloc(v);
         node_nxt[n] = head;
         if (count > 0) node_prv[head] = n;
         else tail = n;
         head = n;
         count++;
         if (cur_pos >= 0) cur_pos++;
      endfunction

      function void push_back(logic signed [VALUE_W-1:0] v);
         int n;
         n = alloc(v);
         if (count == 0) head = n;
         else begin
            node_nxt[tail] = n;
            node_prv[n] = tail;
         end
         tail = n;
         count++;
      endfunction

      function void pop_front();
         int old;
         old = head;
         if (count > 1) head = node_nxt[old];
         else begin
            head = 0; tail = 0;
         end
         give_back(old);
         count--;
         if (cur_pos == 0) cur_pos = -1;
         else if (cur_pos > 0) cur_pos--;
      endfunction

      function void pop_back();
         int old;
         old = tail;
         if (count == 1) begin
            cur_pos = -1; head = 0; tail = 0;
         end else begin
            if (cur_pos == count - 1) cur_pos = -1;
            tail = node_prv[old];
         end
         give_back(old);
         count--;
      endfunction

      function logic [ERR_W-1:0] apply(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] v);
         int n, p, nx;
         case (cmd)
            CMD_FRONT: if (count != 0) begin
               cur_slot = head; cur_pos = 0;
            end
            CMD_BACK: if (count != 0) begin
               cur_slot = tail; cur_pos = count - 1;
            end
            CMD_PREV: if (cur_pos >= 0) begin
               if (cur_pos == 0) cur_pos = -1;
               else begin
                  cur_slot = node_prv[cur_slot]; cur_pos--;
               end
            end
            CMD_NEXT: if (cur_pos >= 0) begin
               if (cur_pos == count - 1) cur_pos = -1;
               else begin
                  cur_slot = node_nxt[cur_slot]; cur_pos++;
               end
            end
            CMD_PREPEND, CMD_APPEND: begin
               if (free_n == 0) return ERR_FULL;
               if (cmd == CMD_PREPEND) push_front(v);
               else push_back(v);
            end
            CMD_INS_BEFORE: begin
               if (cur_pos < 0) return ERR_CURSOR;
               if (free_n == 0) return ERR_FULL;
               if (cur_pos == 0) push_front(v);
               else begin
                  n = alloc(v);
                  p = node_prv[cur_slot];
                  node_prv[n] = p; node_nxt[n] = cur_slot;
                  node_nxt[p] = n; node_prv[cur_slot] = n;
                  cur_pos++; count++;
               end
            end
            CMD_INS_AFTER: begin
               if (cur_pos < 0) return ERR_CURSOR;
               if (free_n == 0) return ERR_FULL;
               if (cur_pos == count - 1) push_back(v);
               else begin
                  n = alloc(v);
                  nx = node_nxt[cur_slot];
                  node_prv[nx] = n; node_nxt[n] = nx;
                  node_nxt[cur_slot] = n; node_prv[n] = cur_slot;
                  count++;
               end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK: begin
               if (count == 0) return ERR_EMPTY;
               if (cmd == CMD_DEL_FRONT) pop_front();
               else pop_back();
            end
            CMD_DEL_CURSOR: begin
               if (cur_pos < 0) return ERR_CURSOR;
               if (cur_pos == 0) pop_front();
               else begin
                  n = cur_slot; p = node_prv[n]; nx = node_nxt[n];
                  node_nxt[p] = nx;
                  if (cur_pos == count - 1) tail = p;
                  else node_prv[nx] = p;
                  give_back(n);
                  count--;
               end
               cur_pos = -1;
            end
            CMD_CLEAR: wipe();
            default: ;
         endcase
         return ERR_OK;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] v);
         list_view_type e;
         e.err   = apply(cmd, v);
         e.len   = count[CNT_W-1:0];
         e.pos   = cur_pos[CNT_W-1:0];
         e.front = count != 0 ? node_val[head] : '0;
         e.back  = count != 0 ? node_val[tail] : '0;
         e.curv  = cur_pos >= 0 ? node_val[cur_slot] : '0;
         pending.push_back(e);
      endfunction

      function void field(string name, longint e, longint a);
         if (e != a) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_result(list_view_type a);
         list_view_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected result: expected none actual len %0d", $time, a.len);
            errors++;
            return;
         end
         e = pending.pop_front();
         field("error", e.err, a.err);
         field("list_length", e.len, a.len);
         field("cursor_position", $signed(e.pos), $signed(a.pos));
         field("front_value", e.front, a.front);
         field("back_value", e.back, a.back);
         field("cursor_value", e.curv, a.curv);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [CMD_W-1:0] req_cmd = CMD_QUERY;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic [ERR_W-1:0] rsp_error;
   logic [CNT_W-1:0] rsp_list_length;
   logic signed [CNT_W-1:0] rsp_cursor_position;
   logic signed [VALUE_W-1:0] rsp_front_value, rsp_back_value, rsp_cursor_value;

   list_scoreboard sb = new();
   int idle_cycles = 0;
   bit accepted;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   cursor_list_engine DUT (.*);

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result('{rsp_error, rsp_list_length, rsp_cursor_position,
                           rsp_front_value, rsp_back_value, rsp_cursor_value});
      if (rsp_valid || accepted || reset) idle_cycles = 0;
      else idle_cycles++;
      accepted = 0;
      if (idle_cycles >= 5000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic issue(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] v);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      repeat (gap) @(negedge clock);
      start = 1; req_cmd = cmd; req_value = v;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_request(cmd, v);
      accepted = 1;
      @(negedge clock);
      start = 0;
      req_cmd = logic'($urandom_range(0, 1)) ? CMD_CLEAR : CMD_QUERY;
      req_value = $urandom;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int grow;
      logic [CMD_W-1:0] c;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      issue(CMD_QUERY, 0);
      issue(CMD_FRONT, 0);
      issue(CMD_NEXT, 0);
      issue(CMD_DEL_FRONT, 0);
      issue(CMD_DEL_BACK, 0);
      issue(CMD_DEL_CURSOR, 0);
      issue(CMD_INS_BEFORE, 5);
      issue(CMD_APPEND, 32'h8000_0000);
      issue(CMD_APPEND, 32'h7FFF_FFFF);
      issue(CMD_PREPEND, -1);
      issue(CMD_BACK, 0);
      issue(CMD_NEXT, 0);
      issue(CMD_FRONT, 0);
      issue(CMD_PREV, 0);
      issue(CMD_FRONT, 0);
      issue(CMD_INS_BEFORE, 11);
      issue(CMD_NEXT, 0);
      issue(CMD_INS_AFTER, 22);
      issue(CMD_INS_BEFORE, 33);
      issue(CMD_BACK, 0);
      issue(CMD_INS_AFTER, 44);
      issue(CMD_DEL_CURSOR, 0);
      issue(4'd13, 0);
      issue(4'd15, 0);
      issue(CMD_CLEAR, 0);
      drain();

      for (int i = 0; i < 1350; i++) begin
         if (i % 150 == 0) grow = $urandom_range(0, 2);
         if (i == 700) drain();
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:
               c = (grow != 0) ? CMD_W'(CMD_PREPEND + $urandom_range(0, 3))
                               : CMD_W'(CMD_DEL_FRONT + $urandom_range(0, 2));
            6, 7, 8: c = CMD_W'(CMD_PREPEND + $urandom_range(0, 3));
            9, 10: c = CMD_W'(CMD_DEL_FRONT + $urandom_range(0, 2));
            11, 12, 13, 14, 15: c = CMD_W'(CMD_FRONT + $urandom_range(0, 3));
            16: c = ($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_QUERY;
            default: c = CMD_W'($urandom_range(0, 15));
         endcase
         issue(c, pick_value());
      end
      drain();
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
